### rtl/ptsm_pkg.sv
// Package for the per-thread spill marker: request and result transfer types,
// request kinds, register indexes and spill status codes. No dependencies.
`default_nettype none
package ptsm_pkg;

    localparam int AMOUNT_W = 48;
    localparam int RESULT_W = 52;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [3:0]          thread_index;
        logic [AMOUNT_W-1:0] amount;
    } ptsm_in_t;

    typedef struct packed {
        logic                granted;
        logic [RESULT_W-1:0] result_amount;
    } ptsm_out_t;

    localparam logic [2:0] REQ_UPDATE  = 3'd0;
    localparam logic [2:0] REQ_TRIGGER = 3'd1;
    localparam logic [2:0] REQ_FINISH  = 3'd2;
    localparam logic [2:0] REQ_MARK    = 3'd3;
    localparam logic [2:0] REQ_TOTAL   = 3'd4;

    localparam logic [2:0] REG_SPILLABLE_STAGE = 3'd0;
    localparam logic [2:0] REG_SPILL_ENABLED   = 3'd1;
    localparam logic [2:0] REG_AUTO_MODE       = 3'd2;
    localparam logic [2:0] REG_THRESHOLD       = 3'd3;
    localparam logic [2:0] REG_CACHED_LIMIT    = 3'd4;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_NEED = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

endpackage
`default_nettype wire

### rtl/per_thread_spill_marker_core.sv
// Per-thread spill marker: per-thread byte counts and spill status kept in one
// synchronous memory, updated by read-modify-write. Depends on ptsm_pkg.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_data, one transfer per request, and
//   each yields exactly one result transfer on m_valid/m_ready/m_data.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
//   user must do so only while no request is in flight, which the block does
//   not enforce; cfg_ready is always high. Update, finish and mark pass from
//   acceptance through RMW_RD, RMW_WR and DONE; a bad thread index or an unknown
//   kind goes straight to DONE. Trigger and total sweep the whole table through
//   the single memory read port, one entry per cycle. One request is in work at
//   a time; s_ready is high once the previous result is in the output register.
//   If the receiver stalls, the result waits in the output register; the next
//   request is still accepted and processed, and its result waits until the
//   output register frees up.
//   Reset (aresetn low, synchronous) clears the registers and the per-entry
//   valid bits, so every thread reads as count 0, status none.
`default_nettype none
module per_thread_spill_marker_core #(
    parameter int THREADS = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  ptsm_pkg::ptsm_in_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output ptsm_pkg::ptsm_out_t  m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [2:0]           cfg_index,
    input  wire  [47:0]          cfg_data
);
    import ptsm_pkg::*;

    localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1) > 0 ? $clog2(THREADS + 1) : 1;
    localparam logic [8:0]    THREADS_W = 9'(THREADS);
    localparam logic [CW-1:0] THREADS_C = CW'(THREADS);

    typedef struct packed {
        logic [1:0]          status;
        logic [AMOUNT_W-1:0] bytes;
    } entry_t;

    typedef enum logic [2:0] {IDLE, RMW_RD, RMW_WR, SWEEP, DONE} state_t;

    state_t              state_reg;
    ptsm_in_t            req_reg;
    logic [CW-1:0]       cnt_reg;
    logic                pend_reg;
    logic [AW-1:0]       paddr_reg;
    logic [AMOUNT_W-1:0] want_reg, want_next;
    logic                stopped_reg, stopped_next;
    logic [RESULT_W-1:0] sum_reg, sum_next;
    ptsm_out_t           res_reg;
    logic                m_valid_reg;
    ptsm_out_t           m_data_reg;

    logic                stage_reg, enabled_reg, auto_reg;
    logic [AMOUNT_W-1:0] thr_reg, limit_reg;

    entry_t              mem [THREADS];
    entry_t              mem_q_reg;
    logic                mem_vq_reg;
    logic [THREADS-1:0]  valid_reg;

    logic                s_accept;
    logic                may_spill;
    logic [8:0]          req_idx_wide, in_idx_wide;
    logic [AW-1:0]       idx_addr;
    logic                in_idx_ok;
    logic                issue;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_entry;
    entry_t              ent;
    logic                rmw_grant;
    logic [RESULT_W:0]   sum_full;

    assign s_ready   = (state_reg == IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign may_spill    = stage_reg && enabled_reg;
    assign req_idx_wide = 9'(req_reg.thread_index);
    assign in_idx_wide  = 9'(s_data.thread_index);
    assign idx_addr     = req_idx_wide[AW-1:0];
    assign in_idx_ok    = in_idx_wide < THREADS_W;
    assign issue        = (state_reg == SWEEP) && (cnt_reg < THREADS_C);

    assign rd_en   = (state_reg == RMW_RD) || issue;
    assign rd_addr = (state_reg == RMW_RD) ? idx_addr : cnt_reg[AW-1:0];
    assign ent     = mem_vq_reg ? mem_q_reg : '0;

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = paddr_reg;
        wr_entry     = ent;
        want_next    = want_reg;
        stopped_next = stopped_reg;
        sum_next     = sum_reg;
        rmw_grant    = 1'b0;
        sum_full     = {1'b0, sum_reg} + (RESULT_W+1)'(ent.bytes);
        case (state_reg)
            RMW_WR: begin
                wr_addr = idx_addr;
                case (req_reg.req_type)
                    REQ_UPDATE: begin
                        if (may_spill) begin
                            wr_en          = 1'b1;
                            wr_entry.bytes = req_reg.amount;
                            if (req_reg.amount != '0) begin
                                if (auto_reg) begin
                                    if (ent.status == ST_NEED) begin
                                        wr_entry.status = ST_WAIT;
                                        rmw_grant       = 1'b1;
                                    end
                                end else if (thr_reg != '0 && req_reg.amount > thr_reg) begin
                                    wr_entry.bytes = '0;
                                    rmw_grant      = 1'b1;
                                end
                            end
                        end
                    end
                    REQ_FINISH: begin
                        wr_en    = 1'b1;
                        wr_entry = '0;
                    end
                    REQ_MARK: begin
                        if (may_spill && ent.bytes != '0 && ent.status == ST_NONE) begin
                            wr_en           = 1'b1;
                            wr_entry.status = ST_NEED;
                            rmw_grant       = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            SWEEP: begin
                if (pend_reg) begin
                    if (req_reg.req_type == REQ_TRIGGER) begin
                        if (!stopped_reg) begin
                            if (ent.bytes != '0) begin
                                if (ent.status == ST_NONE) begin
                                    wr_en           = 1'b1;
                                    wr_entry.status = ST_NEED;
                                end
                                want_next = (want_reg > ent.bytes) ? want_reg - ent.bytes : '0;
                                if (want_next == '0) begin
                                    stopped_next = 1'b1;
                                end
                            end
                        end else if (limit_reg != '0 && ent.bytes >= limit_reg
                                     && ent.status == ST_NONE) begin
                            wr_en           = 1'b1;
                            wr_entry.status = ST_NEED;
                        end
                    end else begin
                        sum_next = sum_full[RESULT_W] ? '1 : sum_full[RESULT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // table memory, one read and one write port, valid bits for reset state
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg  <= mem[rd_addr];
            mem_vq_reg <= valid_reg[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= 1'b0;
            enabled_reg <= 1'b0;
            auto_reg    <= 1'b0;
            thr_reg     <= '0;
            limit_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPILLABLE_STAGE: stage_reg   <= cfg_data[0];
                REG_SPILL_ENABLED:   enabled_reg <= cfg_data[0];
                REG_AUTO_MODE:       auto_reg    <= cfg_data[0];
                REG_THRESHOLD:       thr_reg     <= cfg_data;
                REG_CACHED_LIMIT:    limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_accept) begin
                        req_reg     <= s_data;
                        cnt_reg     <= '0;
                        pend_reg    <= 1'b0;
                        want_reg    <= s_data.amount;
                        stopped_reg <= 1'b0;
                        sum_reg     <= '0;
                        res_reg     <= '0;
                        if (s_data.req_type inside {REQ_UPDATE, REQ_FINISH, REQ_MARK}) begin
                            state_reg <= in_idx_ok ? RMW_RD : DONE;
                        end else if (s_data.req_type inside {REQ_TRIGGER, REQ_TOTAL}) begin
                            state_reg <= SWEEP;
                        end else begin
                            state_reg <= DONE;
                        end
                    end
                end
                RMW_RD: begin
                    state_reg <= RMW_WR;
                end
                RMW_WR: begin
                    res_reg.granted       <= rmw_grant;
                    res_reg.result_amount <= '0;
                    state_reg             <= DONE;
                end
                SWEEP: begin
                    pend_reg    <= issue;
                    paddr_reg   <= cnt_reg[AW-1:0];
                    want_reg    <= want_next;
                    stopped_reg <= stopped_next;
                    sum_reg     <= sum_next;
                    if (issue) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (!issue && !pend_reg) begin
                        res_reg.granted       <= 1'b0;
                        res_reg.result_amount <= (req_reg.req_type == REQ_TRIGGER)
                                                 ? RESULT_W'(want_reg) : sum_reg;
                        state_reg             <= DONE;
                    end
                end
                DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
